// File: rtl/core/ftil_pkg.sv
// Shared types, constants and helpers for the filtered top-k insertion list.
`timescale 1ns / 1ps
package ftil_pkg;

  localparam int LIST_CAPACITY = 16;
  localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
  localparam int K_W           = 5;
  localparam int LIM_W         = (CNT_W > K_W) ? CNT_W : K_W;
  localparam int OFFSET_W      = 32;
  localparam int DIST_W        = 32;

  localparam logic [K_W-1:0] K_LIMIT_RESET = K_W'(16);

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_END   = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [DIST_W-1:0]   distance;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] eff_limit(input logic [K_W-1:0] k);
    logic [LIM_W-1:0] kx;
    logic [LIM_W-1:0] res;
    kx = LIM_W'(k);
    if (kx == '0) begin
      res = LIM_W'(1);
    end else if (kx > LIM_W'(LIST_CAPACITY)) begin
      res = LIM_W'(LIST_CAPACITY);
    end else begin
      res = kx;
    end
    return CNT_W'(res);
  endfunction

endpackage

// File: rtl/core/filtered_topk_insertion_list_unit.sv
// Top level: filtered top-k insertion list built from a row of compare-and-shift cells.
// Offer request: accepted while not busy, one per cycle back to back, no result.
// End request, empty list: one result on out_strobe in the cycle after acceptance.
// End request, n entries: busy in ST_READ while the cell row shifts one entry out per
//   cycle; results, one per entry, come back to back through res_r.
// Results cannot be stalled. Synchronous reset empties the list and sets k_limit to 16.
`timescale 1ns / 1ps
module filtered_topk_insertion_list_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [ftil_pkg::OFFSET_W-1:0]  in_row_offset,
  input  logic signed [ftil_pkg::DIST_W-1:0] in_distance,
  input  logic                           in_pass,
  input  logic                           cfg_we,
  input  logic [ftil_pkg::K_W-1:0]       cfg_wdata,
  output logic                           out_strobe,
  output logic [ftil_pkg::OFFSET_W-1:0]  out_offset,
  output logic signed [ftil_pkg::DIST_W-1:0] out_distance,
  output logic                           out_entry_valid,
  output logic                           out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  localparam int CAP = ftil_pkg::LIST_CAPACITY;

  state_t                      state_r, state_nxt;
  logic [ftil_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ftil_pkg::K_W-1:0]    k_limit_r;
  logic                        strobe_r, strobe_nxt;
  logic                        entry_valid_r, entry_valid_nxt;
  logic                        last_r, last_nxt;
  ftil_pkg::entry_t            res_r, res_nxt;

  ftil_pkg::entry_t            new_item;
  ftil_pkg::cell_ctl_t         ctl;
  ftil_pkg::entry_t            item_w [CAP];
  logic                        gt_w   [CAP];
  logic                        valid_w[CAP];
  logic                        accept;

  assign busy     = (state_r == ST_READ);
  assign accept   = start && !busy;
  assign new_item = '{offset: in_row_offset, distance: in_distance};

  always_comb begin
    ctl.insert = accept && (in_action == ftil_pkg::ACT_OFFER) && in_pass
                 && (count_r < ftil_pkg::eff_limit(k_limit_r));
    ctl.shift  = (state_r == ST_READ);
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    ftil_pkg::entry_t left_item;
    ftil_pkg::entry_t right_item;
    logic             left_gt;
    logic             left_valid;

    assign valid_w[i] = (count_r > ftil_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_item  = new_item;
      assign left_gt    = 1'b0;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_item  = item_w[i-1];
      assign left_gt    = gt_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_item = item_w[i];
    end else begin : g_inner
      assign right_item = item_w[i+1];
    end

    ftil_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_item   (new_item),
      .valid_i    (valid_w[i]),
      .left_gt    (left_gt),
      .left_valid (left_valid),
      .left_item  (left_item),
      .right_item (right_item),
      .item_o     (item_w[i]),
      .gt_o       (gt_w[i])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    strobe_nxt      = 1'b0;
    entry_valid_nxt = 1'b0;
    last_nxt        = 1'b0;
    res_nxt         = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ftil_pkg::ACT_END) begin
            if (count_r == '0) begin
              strobe_nxt = 1'b1;
              last_nxt   = 1'b1;
              res_nxt    = '0;
            end else begin
              state_nxt = ST_READ;
            end
          end else if (ctl.insert) begin
            count_nxt = count_r + ftil_pkg::CNT_W'(1);
          end
        end
      end
      ST_READ: begin
        strobe_nxt      = 1'b1;
        entry_valid_nxt = 1'b1;
        res_nxt         = item_w[0];
        last_nxt        = (count_r == ftil_pkg::CNT_W'(1));
        count_nxt       = count_r - ftil_pkg::CNT_W'(1);
        if (count_r == ftil_pkg::CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      k_limit_r <= ftil_pkg::K_LIMIT_RESET;
      strobe_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        k_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_valid_r <= entry_valid_nxt;
    last_r        <= last_nxt;
    res_r         <= res_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_entry_valid = entry_valid_r;
  assign out_last        = last_r;
  assign out_offset      = res_r.offset;
  assign out_distance    = $signed(res_r.distance);

endmodule

// File: rtl/core/ftil_cell.sv
// One compare-and-shift cell of the sorted list.
`timescale 1ns / 1ps
module ftil_cell (
  input  logic              clk,
  input  ftil_pkg::cell_ctl_t ctl,
  input  ftil_pkg::entry_t  new_item,
  input  logic              valid_i,
  input  logic              left_gt,
  input  logic              left_valid,
  input  ftil_pkg::entry_t  left_item,
  input  ftil_pkg::entry_t  right_item,
  output ftil_pkg::entry_t  item_o,
  output logic              gt_o
);

  ftil_pkg::entry_t item_r;
  ftil_pkg::entry_t item_nxt;
  logic             gt;

  assign gt     = valid_i && ($signed(item_r.distance) > $signed(new_item.distance));
  assign gt_o   = gt;
  assign item_o = item_r;

  always_comb begin
    item_nxt = item_r;
    priority if (ctl.shift) begin
      item_nxt = right_item;
    end else if (ctl.insert) begin
      if (left_gt) begin
        item_nxt = left_item;
      end else if ((gt || !valid_i) && left_valid) begin
        item_nxt = new_item;
      end
    end else begin
      item_nxt = item_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// File: rtl/core/ftil_checker.sv
// Port-level checks for the filtered top-k insertion list, bound to the top level.
`timescale 1ns / 1ps
module ftil_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_action,
  input logic                          out_strobe,
  input logic [ftil_pkg::OFFSET_W-1:0] out_offset,
  input logic [ftil_pkg::DIST_W-1:0]   out_distance,
  input logic                          out_entry_valid,
  input logic                          out_last
);

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_entry_valid |-> out_last)
    else $error("empty result without last mark");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_entry_valid |-> (out_offset == '0) && (out_distance == '0))
    else $error("empty result carries non-zero payload");

  a_end_responds: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ftil_pkg::ACT_END) |=> out_strobe || busy)
    else $error("end request neither answered nor started readout");

  a_readout_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("readout stopped before last result");

  a_readout_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_entry_valid)
    else $error("gap inside readout");

endmodule

bind filtered_topk_insertion_list_unit ftil_checker u_ftil_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_strobe      (out_strobe),
  .out_offset      (out_offset),
  .out_distance    (out_distance),
  .out_entry_valid (out_entry_valid),
  .out_last        (out_last)
);
